### src/apdc_pkg.sv
// Shared types and constants for the saturated PD control pipeline.
package apdc_pkg;

    localparam int DIM       = 3;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int ADDR_W    = 4;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = SUM_W / 2;

    localparam logic [GAIN_W-1:0] MAG_MAX         = '1;
    localparam logic [GAIN_W-1:0] GAIN_POS_RST    = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] GAIN_VEL_RST    = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] VEL_LIMIT_RST   = '1;
    localparam logic [GAIN_W-1:0] ACCEL_LIMIT_RST = '1;

    // norm limiter: square, sum, compare, root, product, divide, output register
    localparam int NORM_LAT = 3 + ROOT_W + 1 + GAIN_W + 1;

    typedef enum logic [1:0] {
        REG_GAIN_POS    = 2'd0,
        REG_GAIN_VEL    = 2'd1,
        REG_VEL_LIMIT   = 2'd2,
        REG_ACCEL_LIMIT = 2'd3
    } reg_idx_t;

    typedef logic [GAIN_W-1:0] mag_t;
    typedef mag_t [DIM-1:0]    mag_vec_t;

    typedef struct packed {
        logic           valid;
        logic [DIM-1:0] neg;
    } ctl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] target_0;
        logic signed [DATA_W-1:0] target_1;
        logic signed [DATA_W-1:0] target_2;
        logic signed [DATA_W-1:0] pos_0;
        logic signed [DATA_W-1:0] pos_1;
        logic signed [DATA_W-1:0] pos_2;
        logic signed [DATA_W-1:0] vel_0;
        logic signed [DATA_W-1:0] vel_1;
        logic signed [DATA_W-1:0] vel_2;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive_0;
        logic signed [DATA_W-1:0] drive_1;
        logic signed [DATA_W-1:0] drive_2;
    } result_t;

endpackage

### src/apdc_dly.sv
// Fixed-length delay line with reset.
module apdc_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [0:N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                sr_reg[i] <= '0;
            end
        end
        else
        begin
            sr_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule

### src/apdc_div.sv
// Pipelined restoring divider, one quotient bit per stage; needs num < den << QW.
module apdc_div #(
    parameter int DW = 31,
    parameter int QW = 31
) (
    input  logic            clk,
    input  logic [DW+QW-1:0] num,
    input  logic [DW-1:0]    den,
    output logic [QW-1:0]    quo
);

    localparam int NW = DW + QW;

    logic [NW-1:0] rem_reg [0:QW-2];
    logic [DW-1:0] den_reg [0:QW-2];
    logic [QW-1:0] quo_reg [0:QW-1];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [NW-1:0] rem_prev;
        logic [DW-1:0] den_prev;
        logic [QW-1:0] quo_prev;
        logic [NW-1:0] sub;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_prev = num;
            assign den_prev = den;
            assign quo_prev = '0;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[i-1];
            assign den_prev = den_reg[i-1];
            assign quo_prev = quo_reg[i-1];
        end

        assign sub = NW'(den_prev) << (QW - 1 - i);
        assign ge  = rem_prev >= sub;

        always_ff @(posedge clk)
        begin
            quo_reg[i] <= (quo_prev << 1) | QW'(ge);
        end

        if (i < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[i] <= ge ? rem_prev - sub : rem_prev;
                den_reg[i] <= den_prev;
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

### src/apdc_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module apdc_sqrt #(
    parameter int IW = 64
) (
    input  logic            clk,
    input  logic [IW-1:0]   x,
    output logic [IW/2-1:0] root
);

    localparam int OW = IW / 2;
    localparam int RW = OW + 2;

    logic [IW-1:0] x_reg [0:OW-1];
    logic [RW-1:0] r_reg [0:OW-1];
    logic [OW-1:0] q_reg [0:OW-1];

    for (genvar i = 0; i < OW; i++)
    begin : g_stage
        logic [IW-1:0] x_prev;
        logic [RW-1:0] r_prev;
        logic [OW-1:0] q_prev;
        logic [RW+1:0] r_sh;
        logic [RW+1:0] trial;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign x_prev = x;
            assign r_prev = '0;
            assign q_prev = '0;
        end
        else
        begin : g_next
            assign x_prev = x_reg[i-1];
            assign r_prev = r_reg[i-1];
            assign q_prev = q_reg[i-1];
        end

        // bring down two bits, try (2q)*2 + 1
        assign r_sh  = {r_prev, x_prev[IW-1:IW-2]};
        assign trial = {2'b00, q_prev, 2'b01};
        assign ge    = r_sh >= trial;

        always_ff @(posedge clk)
        begin
            x_reg[i] <= x_prev << 2;
            r_reg[i] <= ge ? RW'(r_sh - trial) : RW'(r_sh);
            q_reg[i] <= {q_prev[OW-2:0], ge};
        end
    end

    assign root = q_reg[OW-1];

endmodule

### src/apdc_norm.sv
// Euclidean norm limiter: scales a magnitude vector down to a limit.
module apdc_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  apdc_pkg::ctl_t     in_ctl,
    input  apdc_pkg::mag_vec_t in_mag,
    input  apdc_pkg::mag_t     lim,
    output apdc_pkg::ctl_t     out_ctl,
    output apdc_pkg::mag_vec_t out_mag
);

    localparam int GW     = apdc_pkg::GAIN_W;
    localparam int PW     = 2 * GW;
    localparam int RTW    = apdc_pkg::ROOT_W;
    localparam int CW     = $bits(apdc_pkg::ctl_t) + $bits(apdc_pkg::mag_vec_t);
    localparam int LAT_A  = 3 + RTW;
    localparam int LAT_B  = 1 + GW;

    logic [PW-1:0]               sq_reg [apdc_pkg::DIM];
    logic [apdc_pkg::SUM_W-1:0]  sum_reg;
    logic [apdc_pkg::SUM_W-1:0]  sum3_reg;
    logic [PW-1:0]               ll_reg;
    logic                        over_reg;
    logic [apdc_pkg::SUM_W-1:0]  sum_next;
    logic [RTW-1:0]              root;
    logic [RTW-1:0]              den_reg;
    logic [PW-1:0]               prod_reg [apdc_pkg::DIM];
    logic [GW-1:0]               quo [apdc_pkg::DIM];
    logic                        over_d;
    apdc_pkg::ctl_t              ctl_a;
    apdc_pkg::mag_vec_t          mag_a;
    apdc_pkg::ctl_t              ctl_b;
    apdc_pkg::mag_vec_t          mag_b;
    apdc_pkg::ctl_t              out_ctl_reg;
    apdc_pkg::mag_vec_t          out_mag_reg;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < apdc_pkg::DIM; i++)
        begin
            sum_next = sum_next + apdc_pkg::SUM_W'(sq_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < apdc_pkg::DIM; i++)
        begin
            sq_reg[i] <= PW'(in_mag[i]) * PW'(in_mag[i]);
        end
        sum_reg  <= sum_next;
        ll_reg   <= PW'(lim) * PW'(lim);
        over_reg <= sum_reg > apdc_pkg::SUM_W'(ll_reg);
        sum3_reg <= sum_reg;
    end

    apdc_sqrt #(.IW(apdc_pkg::SUM_W)) u_sqrt (
        .clk  (clk),
        .x    (sum3_reg),
        .root (root)
    );

    apdc_dly #(.W(CW), .N(LAT_A)) u_dly_a (
        .clk   (clk),
        .rst_n (rst_n),
        .d     ({in_ctl, in_mag}),
        .q     ({ctl_a, mag_a})
    );

    // numerator is in the divider's range whenever the root is nonzero
    always_ff @(posedge clk)
    begin
        den_reg <= root;
        for (int i = 0; i < apdc_pkg::DIM; i++)
        begin
            prod_reg[i] <= PW'(mag_a[i]) * PW'(lim);
        end
    end

    for (genvar i = 0; i < apdc_pkg::DIM; i++)
    begin : g_lane
        apdc_div #(.DW(RTW), .QW(GW)) u_div (
            .clk (clk),
            .num ((RTW + GW)'(prod_reg[i])),
            .den (den_reg),
            .quo (quo[i])
        );
    end

    apdc_dly #(.W(CW), .N(LAT_B)) u_dly_b (
        .clk   (clk),
        .rst_n (rst_n),
        .d     ({ctl_a, mag_a}),
        .q     ({ctl_b, mag_b})
    );

    apdc_dly #(.W(1), .N(RTW + LAT_B)) u_dly_over (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (over_reg),
        .q     (over_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg <= '0;
        end
        else
        begin
            out_ctl_reg <= ctl_b;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < apdc_pkg::DIM; i++)
        begin
            out_mag_reg[i] <= over_d ? quo[i] : mag_b[i];
        end
    end

    assign out_ctl = out_ctl_reg;
    assign out_mag = out_mag_reg;

endmodule

### src/accel_saturated_pd_control.sv
// Top level: saturated PD control pipeline with APB register port.
//
// Usage: raise start with a command item on cmd (target, position and
// velocity vectors, signed fixed point). busy is held low, so an item is
// taken on every cycle that start is high: one item per clock sustained.
// Each item yields one result on the result port, marked by done for
// exactly one cycle. The chain runs through the gain divide (31 stages),
// two norm limiters (each a 32-stage square root and a 31-stage divide)
// and the error, multiply and clamp stages A to G. The receiver cannot
// stall; results are never held.
// Registers (gain_pos, gain_vel, vel_limit, accel_limit) sit on the APB
// port at byte offsets 0, 4, 8, 12; write them only while no item is in
// flight. Reset clears all valid bits and loads the register defaults
// (unity gains, maximum limits); no clearing pass is needed.
module accel_saturated_pd_control #(
    parameter int FRAC_BITS = apdc_pkg::FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  apdc_pkg::cmd_t              cmd,
    output logic                        done,
    output apdc_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [apdc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int DIM   = apdc_pkg::DIM;
    localparam int DW    = apdc_pkg::DATA_W;
    localparam int GW    = apdc_pkg::GAIN_W;
    localparam int EW    = DW + 1;
    localparam int PW    = 2 * DW;
    localparam int VW    = DIM * DW;
    localparam int CW    = $bits(apdc_pkg::ctl_t);
    localparam int LAT_VEL = 2 + GW + apdc_pkg::NORM_LAT;

    // configuration registers
    apdc_pkg::mag_t   gain_pos_reg;
    apdc_pkg::mag_t   gain_vel_reg;
    apdc_pkg::mag_t   vel_limit_reg;
    apdc_pkg::mag_t   accel_limit_reg;
    apdc_pkg::reg_idx_t reg_idx;
    logic             cfg_wr;
    apdc_pkg::mag_t   div_val;

    assign reg_idx = apdc_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_pos_reg    <= apdc_pkg::GAIN_POS_RST;
            gain_vel_reg    <= apdc_pkg::GAIN_VEL_RST;
            vel_limit_reg   <= apdc_pkg::VEL_LIMIT_RST;
            accel_limit_reg <= apdc_pkg::ACCEL_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                apdc_pkg::REG_GAIN_POS:    gain_pos_reg    <= pwdata[GW-1:0];
                apdc_pkg::REG_GAIN_VEL:    gain_vel_reg    <= pwdata[GW-1:0];
                apdc_pkg::REG_VEL_LIMIT:   vel_limit_reg   <= pwdata[GW-1:0];
                apdc_pkg::REG_ACCEL_LIMIT: accel_limit_reg <= pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            apdc_pkg::REG_GAIN_POS:    prdata = 32'(gain_pos_reg);
            apdc_pkg::REG_GAIN_VEL:    prdata = 32'(gain_vel_reg);
            apdc_pkg::REG_VEL_LIMIT:   prdata = 32'(vel_limit_reg);
            apdc_pkg::REG_ACCEL_LIMIT: prdata = 32'(accel_limit_reg);
            default:                   prdata = '0;
        endcase
    end

    // zero velocity gain divides by one
    assign div_val = (gain_vel_reg == '0) ? GW'(1) : gain_vel_reg;

    // unpack item
    logic signed [DW-1:0] target [DIM];
    logic signed [DW-1:0] pos    [DIM];
    logic [VW-1:0]        vel_in;

    assign target[0] = cmd.target_0;
    assign target[1] = cmd.target_1;
    assign target[2] = cmd.target_2;
    assign pos[0]    = cmd.pos_0;
    assign pos[1]    = cmd.pos_1;
    assign pos[2]    = cmd.pos_2;
    assign vel_in    = {cmd.vel_2, cmd.vel_1, cmd.vel_0};

    // stage A: position error magnitude and sign
    apdc_pkg::ctl_t       a_ctl_reg;
    logic [EW-1:0]        a_mag_reg [DIM];
    logic [VW-1:0]        a_vel_reg;
    logic signed [EW-1:0] a_err [DIM];
    logic [DIM-1:0]       a_neg_next;

    always_comb
    begin
        for (int i = 0; i < DIM; i++)
        begin
            a_err[i]      = EW'(pos[i]) - EW'(target[i]);
            a_neg_next[i] = !a_err[i][EW-1] && (a_err[i] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg.valid <= start;
            a_ctl_reg.neg   <= a_neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_vel_reg <= vel_in;
        for (int i = 0; i < DIM; i++)
        begin
            a_mag_reg[i] <= a_err[i][EW-1] ? EW'(-a_err[i]) : EW'(a_err[i]);
        end
    end

    // stage B: error times kp
    apdc_pkg::ctl_t b_ctl_reg;
    logic [PW-1:0]  b_prod_reg [DIM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg <= '0;
        end
        else
        begin
            b_ctl_reg <= a_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIM; i++)
        begin
            b_prod_reg[i] <= PW'(a_mag_reg[i]) * PW'(gain_pos_reg);
        end
    end

    // stage C: saturation check ahead of the kv divide
    apdc_pkg::ctl_t    c_ctl_reg;
    logic [DIM-1:0]    c_sat_reg;
    logic [2*GW-1:0]   c_num_reg [DIM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctl_reg <= '0;
        end
        else
        begin
            c_ctl_reg <= b_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIM; i++)
        begin
            c_sat_reg[i] <= b_prod_reg[i] >= (PW'(div_val) << GW);
            c_num_reg[i] <= b_prod_reg[i][2*GW-1:0];
        end
    end

    logic [GW-1:0]    vd_quo [DIM];
    apdc_pkg::ctl_t   vd_ctl;
    logic [DIM-1:0]   vd_sat;
    apdc_pkg::mag_vec_t vd_mag;

    for (genvar i = 0; i < DIM; i++)
    begin : g_vd_div
        apdc_div #(.DW(GW), .QW(GW)) u_div (
            .clk (clk),
            .num (c_num_reg[i]),
            .den (div_val),
            .quo (vd_quo[i])
        );
        assign vd_mag[i] = vd_sat[i] ? apdc_pkg::MAG_MAX : vd_quo[i];
    end

    apdc_dly #(.W(CW + DIM), .N(GW)) u_dly_vd (
        .clk   (clk),
        .rst_n (rst_n),
        .d     ({c_ctl_reg, c_sat_reg}),
        .q     ({vd_ctl, vd_sat})
    );

    apdc_pkg::ctl_t     n1_ctl;
    apdc_pkg::mag_vec_t n1_mag;

    apdc_norm u_norm_vel (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (vd_ctl),
        .in_mag  (vd_mag),
        .lim     (vel_limit_reg),
        .out_ctl (n1_ctl),
        .out_mag (n1_mag)
    );

    logic [VW-1:0] vel_d;

    apdc_dly #(.W(VW), .N(LAT_VEL)) u_dly_vel (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (a_vel_reg),
        .q     (vel_d)
    );

    // stage D: velocity error
    apdc_pkg::ctl_t       d_ctl_reg;
    logic [EW-1:0]        d_mag_reg [DIM];
    logic signed [EW-1:0] d_vd [DIM];
    logic signed [EW-1:0] d_w  [DIM];
    logic [DIM-1:0]       d_neg_next;

    always_comb
    begin
        for (int i = 0; i < DIM; i++)
        begin
            d_vd[i]       = n1_ctl.neg[i] ? -EW'(n1_mag[i]) : EW'(n1_mag[i]);
            d_w[i]        = EW'(signed'(vel_d[i*DW +: DW])) - d_vd[i];
            d_neg_next[i] = !d_w[i][EW-1] && (d_w[i] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_ctl_reg <= '0;
        end
        else
        begin
            d_ctl_reg.valid <= n1_ctl.valid;
            d_ctl_reg.neg   <= d_neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIM; i++)
        begin
            d_mag_reg[i] <= d_w[i][EW-1] ? EW'(-d_w[i]) : EW'(d_w[i]);
        end
    end

    // stage E: times kv
    apdc_pkg::ctl_t e_ctl_reg;
    logic [PW-1:0]  e_prod_reg [DIM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_ctl_reg <= '0;
        end
        else
        begin
            e_ctl_reg <= d_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIM; i++)
        begin
            e_prod_reg[i] <= PW'(d_mag_reg[i]) * PW'(gain_vel_reg);
        end
    end

    // stage F: rescale and clamp
    apdc_pkg::ctl_t     f_ctl_reg;
    apdc_pkg::mag_vec_t f_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_ctl_reg <= '0;
        end
        else
        begin
            f_ctl_reg <= e_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [PW-1:0] sh;
        for (int i = 0; i < DIM; i++)
        begin
            sh = e_prod_reg[i] >> FRAC_BITS;
            f_mag_reg[i] <= (sh > PW'(apdc_pkg::MAG_MAX)) ? apdc_pkg::MAG_MAX : sh[GW-1:0];
        end
    end

    apdc_pkg::ctl_t     n2_ctl;
    apdc_pkg::mag_vec_t n2_mag;

    apdc_norm u_norm_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (f_ctl_reg),
        .in_mag  (f_mag_reg),
        .lim     (accel_limit_reg),
        .out_ctl (n2_ctl),
        .out_mag (n2_mag)
    );

    // stage G: signed result
    logic              done_reg;
    apdc_pkg::result_t result_reg;
    logic [DW-1:0]     drive_next [DIM];

    for (genvar i = 0; i < DIM; i++)
    begin : g_drive
        assign drive_next[i] = n2_ctl.neg[i] ? -DW'(n2_mag[i]) : DW'(n2_mag[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= n2_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.drive_0 <= drive_next[0];
        result_reg.drive_1 <= drive_next[1];
        result_reg.drive_2 <= drive_next[2];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
